>>> hw/rtl/bfb_pkg.sv
// package: constants, types and hash helpers for the bloom filter bank
package bfb_pkg;

  localparam int unsigned FilterSlots    = 16;
  localparam int unsigned MaxFilterBits  = 4096;
  localparam int unsigned MaxHashes      = 16;
  localparam int unsigned WordsPerFilter = (MaxFilterBits + 63) / 64;
  localparam int unsigned StoreWords     = FilterSlots * WordsPerFilter;
  localparam int unsigned SlotW          = $clog2(FilterSlots);
  localparam int unsigned WordW          = $clog2(WordsPerFilter);
  localparam int unsigned AddrW          = $clog2(StoreWords);
  localparam int unsigned PosW           = $clog2(MaxFilterBits);
  localparam int unsigned MW             = 13;
  localparam int unsigned KW             = 5;

  localparam logic [63:0] Fnv64Basis = 64'd14695981039346656037;
  localparam logic [63:0] Fnv32Basis = 64'd2166136261;

  localparam logic [MW-1:0] MinBits = MW'(64);
  localparam logic [MW-1:0] MaxBits = MW'(MaxFilterBits);
  localparam logic [KW-1:0] MaxK    = KW'(MaxHashes);

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_DROP  = 2'd2,
    KIND_COUNT = 2'd3
  } kind_e;

  typedef enum logic {
    REG_FILTER_BITS = 1'b0,
    REG_HASH_COUNT  = 1'b1
  } reg_idx_e;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MOD   = 7'b0000100,
    ST_RD    = 7'b0001000,
    ST_WR    = 7'b0010000,
    ST_WIPE  = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_e;

  // fnv-1a 64 step: prime is 2^40 + 435
  function automatic logic [63:0] fnv64_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + x * 64'd435;
  endfunction

  // 32-bit fnv prime with 64-bit wrap: prime is 2^24 + 403
  function automatic logic [63:0] fnv32_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 24) + x * 64'd403;
  endfunction

endpackage

>>> hw/rtl/bloom_filter_bank.sv
// Bloom filter bank: 16 filters of up to 4096 bits each in one 1024 x 64 bit synchronous
// memory. Key bytes hash at one beat per cycle while input is not stalled. On the last
// byte a bit-serial remainder unit reduces h1, h2 and 2^64 modulo m, then each of the
// k probes reads a word, then tests or sets the bit and writes it back. Drop wipes an
// existing filter's 64 words. After reset the block clears the whole store and stalls
// input meanwhile. Results sit in an output register, so a new beat can be taken while
// a result waits.
module bloom_filter_bank (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [12:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [3:0]           filter_slot_i,
  input  logic [7:0]           key_byte_i,
  input  logic                 byte_present_i,
  input  logic                 key_last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 might_contain_o,
  output logic                 status_o,
  output logic [31:0]          element_count_o
);
  import bfb_pkg::*;

  state_e state_q, state_d;

  logic [MW-1:0] m_q;
  logic [KW-1:0] k_q;
  logic [MW-1:0] eff_m;
  logic [KW-1:0] eff_k;

  logic [63:0] run1_q, run2_q;
  logic [63:0] h1_q, h2_q, acc_q;
  logic [SlotW-1:0] slot_q;
  logic             add_q;
  logic [FilterSlots-1:0] exists_q;
  logic [31:0] count_q [FilterSlots];

  logic [MW-1:0] r1_q, r2_q, rw_q;
  logic [6:0]    step_q;
  logic [PosW-1:0] pos_q;
  logic [KW-1:0]   probe_q;
  logic [AddrW-1:0] sweep_q;

  logic res_mc_q, res_st_q;
  logic [31:0] res_cnt_q;
  logic out_valid_q, out_mc_q, out_st_q;
  logic [31:0] out_cnt_q;

  logic [63:0] mem [StoreWords];
  logic [63:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [63:0]      mem_wdata;

  logic accept;
  kind_e kind;
  logic [63:0] h1_upd, h2_upd;

  // effective register values
  always_comb begin
    eff_m = m_q;
    if (m_q < MinBits) eff_m = MinBits;
    else if (m_q > MaxBits) eff_m = MaxBits;
    eff_k = k_q;
    if (k_q == '0) eff_k = KW'(1);
    else if (k_q > MaxK) eff_k = MaxK;
  end

  assign kind       = kind_e'(kind_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign h1_upd     = byte_present_i ? fnv64_step(run1_q, key_byte_i) : run1_q;
  assign h2_upd     = byte_present_i ? fnv32_step(run2_q, key_byte_i) : run2_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= MW'(MaxFilterBits);
      k_q <= KW'(7);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FILTER_BITS: m_q <= cfg_data_i;
        REG_HASH_COUNT:  k_q <= cfg_data_i[KW-1:0];
        default: ;
      endcase
    end
  end

  // remainder step bits, msb first over a 65-bit dividend
  logic [6:0] bit_idx;
  logic       b1, b2, bw;
  logic [MW:0] t1, t2, tw;
  assign bit_idx = 7'd64 - step_q;
  assign b1 = (bit_idx == 7'd64) ? 1'b0 : h1_q[bit_idx[5:0]];
  assign b2 = (bit_idx == 7'd64) ? 1'b0 : h2_q[bit_idx[5:0]];
  assign bw = (bit_idx == 7'd64);
  assign t1 = {r1_q, b1};
  assign t2 = {r2_q, b2};
  assign tw = {rw_q, bw};

  // next probe position: (pos + h2 mod m) mod m, corrected for a 64-bit wrap
  logic [64:0]   acc_sum;
  logic [MW+1:0] pa, pb;
  logic [PosW-1:0] pos_next;
  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, h2_q};
    pa = {2'b0, MW'(pos_q)} + {2'b0, r2_q};
    if (pa >= {2'b0, eff_m}) pa = pa - {2'b0, eff_m};
    if (acc_sum[64]) begin
      pb = pa + {2'b0, eff_m} - {2'b0, rw_q};
      if (pb >= {2'b0, eff_m}) pb = pb - {2'b0, eff_m};
    end else begin
      pb = pa;
    end
    pos_next = pb[PosW-1:0];
  end

  logic probe_bit;
  assign probe_bit = rdata_q[pos_q[5:0]];

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {slot_q, pos_q[PosW-1:6]};
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep_q;
      end
      ST_WIPE: begin
        mem_we   = 1'b1;
        mem_addr = {slot_q, sweep_q[WordW-1:0]};
      end
      ST_RD: mem_re = 1'b1;
      ST_WR: begin
        mem_we    = add_q;
        mem_wdata = rdata_q | (64'd1 << pos_q[5:0]);
      end
      default: ;
    endcase
  end

  // bit store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sweep_q == AddrW'(StoreWords - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_ADD: if (key_last_i) state_d = ST_MOD;
            KIND_QUERY: begin
              if (key_last_i) state_d = exists_q[filter_slot_i] ? ST_MOD : ST_RESP;
            end
            KIND_DROP:  state_d = exists_q[filter_slot_i] ? ST_WIPE : ST_RESP;
            KIND_COUNT: state_d = ST_RESP;
            default: ;
          endcase
        end
      end
      ST_MOD:  if (step_q == 7'd64) state_d = ST_RD;
      ST_RD:   state_d = ST_WR;
      ST_WR:   state_d = (probe_q + KW'(1) == eff_k) ? ST_RESP : ST_RD;
      ST_WIPE: if (sweep_q[WordW-1:0] == WordW'(WordsPerFilter - 1)) state_d = ST_RESP;
      ST_RESP: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      sweep_q  <= '0;
      exists_q <= '0;
      run1_q   <= Fnv64Basis;
      run2_q   <= Fnv32Basis;
      out_valid_q <= 1'b0;
      for (int s = 0; s < FilterSlots; s++) count_q[s] <= '0;
    end else begin
      state_q <= state_d;
      // output beat: loaded from the response state, dropped once taken
      if (state_q == ST_RESP && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: sweep_q <= sweep_q + AddrW'(1);
        ST_IDLE: begin
          sweep_q <= '0;
          if (accept) begin
            unique case (kind)
              KIND_ADD, KIND_QUERY: begin
                if (key_last_i) begin
                  run1_q <= Fnv64Basis;
                  run2_q <= Fnv32Basis;
                  if (kind == KIND_ADD) begin
                    exists_q[filter_slot_i] <= 1'b1;
                    if (count_q[filter_slot_i] != 32'hFFFF_FFFF)
                      count_q[filter_slot_i] <= count_q[filter_slot_i] + 32'd1;
                  end
                end else begin
                  run1_q <= h1_upd;
                  run2_q <= h2_upd;
                end
              end
              KIND_DROP: begin
                if (exists_q[filter_slot_i]) begin
                  exists_q[filter_slot_i] <= 1'b0;
                  count_q[filter_slot_i]  <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WIPE: sweep_q <= sweep_q + AddrW'(1);
        default: ;
      endcase
    end
  end

  // key, remainder and probe datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        slot_q    <= filter_slot_i;
        add_q     <= (kind == KIND_ADD);
        h1_q      <= h1_upd;
        h2_q      <= {h2_upd[30:0], h2_upd[63:31]};
        r1_q      <= '0;
        r2_q      <= '0;
        rw_q      <= '0;
        step_q    <= '0;
        probe_q   <= '0;
        res_mc_q  <= (kind == KIND_QUERY) && exists_q[filter_slot_i];
        res_st_q  <= (kind == KIND_ADD) ? 1'b0
                   : (kind == KIND_QUERY) ? 1'b0 : !exists_q[filter_slot_i];
        res_cnt_q <= (kind == KIND_COUNT && exists_q[filter_slot_i])
                   ? count_q[filter_slot_i] : '0;
      end
      ST_MOD: begin
        r1_q   <= (t1 >= {1'b0, eff_m}) ? MW'(t1 - {1'b0, eff_m}) : MW'(t1);
        r2_q   <= (t2 >= {1'b0, eff_m}) ? MW'(t2 - {1'b0, eff_m}) : MW'(t2);
        rw_q   <= (tw >= {1'b0, eff_m}) ? MW'(tw - {1'b0, eff_m}) : MW'(tw);
        step_q <= step_q + 7'd1;
        acc_q  <= h1_q;
        pos_q  <= (t1 >= {1'b0, eff_m}) ? PosW'(t1 - {1'b0, eff_m}) : PosW'(t1);
      end
      ST_WR: begin
        if (!add_q) res_mc_q <= res_mc_q & probe_bit;
        acc_q   <= acc_sum[63:0];
        pos_q   <= pos_next;
        probe_q <= probe_q + KW'(1);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && (!out_valid_q || !out_stall_i)) begin
      out_mc_q  <= res_mc_q;
      out_st_q  <= res_st_q;
      out_cnt_q <= res_cnt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign might_contain_o = out_mc_q;
  assign status_o        = out_st_q;
  assign element_count_o = out_cnt_q;

  // no beat is taken while the store is being cleared after reset
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o)
    else $error("beat accepted during store clear");

  // probe positions always fall inside the filter
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |-> {1'b0, pos_q} < eff_m)
    else $error("probe position beyond filter size");

  // a query never writes the store
  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR && !add_q) |-> !mem_we)
    else $error("query wrote the bit store");

endmodule
